### hdl/ftrm_pkg.sv
// Shared types and constants for the fan tachometer and speed monitor.
package ftrm_pkg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ms;
        logic        auto_demand;
        logic        manual_on;
    } in_item_t;

    typedef struct packed {
        logic        fan_on;
        logic        fault;
        logic [15:0] rpm;
        logic [31:0] window_pulses_seen;
        logic [31:0] total_pulses;
    } res_item_t;

    typedef enum logic {
        CMD_TACH = 1'b0,
        CMD_TICK = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] now_ms;
        logic        want;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_START,
        BK_WAIT,
        BK_EMIT
    } back_state_t;

    localparam logic [1:0] REG_AUTO_MODE   = 2'd0;
    localparam logic [1:0] REG_PUBLISH_INT = 2'd1;
    localparam logic [1:0] REG_FAULT_GRACE = 2'd2;

    localparam logic        RESET_AUTO_MODE   = 1'b0;
    localparam logic [15:0] RESET_PUBLISH_INT = 16'd1000;
    localparam logic [15:0] RESET_FAULT_GRACE = 16'd5000;

    localparam int unsigned RPM_SCALE_BITS = 15;
    localparam logic [14:0] RPM_HALF_SCALE = 15'd30000;
    localparam logic [15:0] RPM_MAX        = 16'hFFFF;
    localparam int unsigned QUOT_W         = 16;
    localparam int unsigned CMD_DEPTH      = 2;

endpackage

### hdl/fan_tach_rpm_monitor.sv
// Top level of the fan switch and tachometer speed monitor with stall detection.
//
//   Channel   Handshake            Payload
//   request   push / full          item   (in_item_t)
//   result    pop / empty          result (res_item_t)
//   config    psel/penable/pready  paddr, pwdata, prdata
//
// A tach request or a tick with no speed calculation goes from idle to emit.
// A recalculating tick adds multiply, start and wait on the 16-step serial divider.
// A two-entry command queue takes requests while the back end works on earlier ones.
// The back end starts the next request in the cycle that the previous result is popped.
// Reset is asynchronous and active low; no clearing pass follows it.
module fan_tach_rpm_monitor #(
    parameter int unsigned PULSE_COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ftrm_pkg::in_item_t  item,
    input  logic                pop,
    output logic                empty,
    output ftrm_pkg::res_item_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ftrm_pkg::*;

    logic        auto_mode_reg;
    logic [15:0] publish_int_reg;
    logic [15:0] fault_grace_reg;
    logic        cfg_write;
    logic        cmd_valid;
    cmd_t        cmd;
    logic        cmd_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_AUTO_MODE:   prdata = {31'd0, auto_mode_reg};
            REG_PUBLISH_INT: prdata = {16'd0, publish_int_reg};
            REG_FAULT_GRACE: prdata = {16'd0, fault_grace_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg   <= RESET_AUTO_MODE;
            publish_int_reg <= RESET_PUBLISH_INT;
            fault_grace_reg <= RESET_FAULT_GRACE;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_AUTO_MODE:   auto_mode_reg   <= pwdata[0];
                REG_PUBLISH_INT: publish_int_reg <= pwdata[15:0];
                REG_FAULT_GRACE: fault_grace_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    ftrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .auto_mode (auto_mode_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ftrm_back #(
        .PULSE_COUNT_WIDTH (PULSE_COUNT_WIDTH)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd_valid           (cmd_valid),
        .cmd                 (cmd),
        .cmd_pop             (cmd_pop),
        .publish_interval_ms (publish_int_reg),
        .fault_grace_ms      (fault_grace_reg),
        .pop                 (pop),
        .empty               (empty),
        .result              (result)
    );

endmodule

### hdl/ftrm_front.sv
// Front end: classifies incoming requests and queues them as commands.
module ftrm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  ftrm_pkg::in_item_t item,
    input  logic             auto_mode,
    output logic             cmd_valid,
    output ftrm_pkg::cmd_t   cmd,
    input  logic             cmd_pop
);
    import ftrm_pkg::*;

    localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
    localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             cmd_mem_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;
    cmd_t             new_cmd;

    assign full      = (count_reg == CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = cmd_mem_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.kind   = item.req_type ? CMD_TICK : CMD_TACH;
        new_cmd.now_ms = item.now_ms;
        new_cmd.want   = auto_mode ? item.auto_demand : item.manual_on;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/ftrm_div.sv
// Serial restoring divider with saturation for the speed calculation.
module ftrm_div #(
    parameter int unsigned NUM_W = 47
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [31:0]      den,
    output logic             done,
    output logic [15:0]      quot
);
    import ftrm_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

    logic [31:0]       rem_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [31:0]       den_reg;
    logic              sat_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic              ge;

    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};
    assign done  = done_reg;
    assign quot  = sat_reg ? RPM_MAX : quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg  <= (48'(num) >= {den, 16'h0000});
            rem_reg  <= 32'(num >> QUOT_W);
            low_reg  <= num[QUOT_W-1:0];
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= ge ? diff[31:0] : trial[31:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(QUOT_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/ftrm_back.sv
// Back end: fan state, pulse counters, speed calculation and result register.
module ftrm_back #(
    parameter int unsigned PULSE_COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ftrm_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    input  logic [15:0]         publish_interval_ms,
    input  logic [15:0]         fault_grace_ms,
    input  logic                pop,
    output logic                empty,
    output ftrm_pkg::res_item_t result
);
    import ftrm_pkg::*;

    localparam int unsigned PW    = PULSE_COUNT_WIDTH;
    localparam int unsigned NUM_W = PW + RPM_SCALE_BITS;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             on_reg;
    logic             fault_reg;
    logic [15:0]      rpm_reg;
    logic [PW-1:0]    window_reg;
    logic [PW-1:0]    last_window_reg;
    logic [PW-1:0]    total_reg;
    logic [31:0]      last_calc_reg;
    logic [31:0]      running_since_reg;
    logic [PW-1:0]    pulses_reg;
    logic [31:0]      elapsed_reg;
    logic             grace_hit_reg;
    logic [NUM_W-1:0] product_reg;
    res_item_t        res_reg;
    logic             res_valid_reg;
    logic             slot_free;
    logic             switching;
    logic [31:0]      elapsed;
    logic             calc_due;
    logic             div_start;
    logic             div_done;
    logic [15:0]      div_quot;
    logic             res_load;

    assign slot_free = !res_valid_reg || pop;
    assign switching = (cmd.want != on_reg);
    assign elapsed   = cmd.now_ms - last_calc_reg;
    assign calc_due  = on_reg && (elapsed >= 32'(publish_interval_ms)) && (elapsed != '0);
    assign empty     = !res_valid_reg;
    assign result    = res_reg;

    ftrm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (product_reg),
        .den   (elapsed_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    if (cmd.kind == CMD_TICK && !switching && calc_due)
                    begin
                        state_next = BK_MUL;
                    end
                    else
                    begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_MUL:   state_next = BK_START;
            BK_START: state_next = BK_WAIT;
            BK_WAIT:
            begin
                if (div_done)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        div_start = 1'b0;
        res_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE:  cmd_pop   = cmd_valid && slot_free;
            BK_START: div_start = 1'b1;
            BK_EMIT:  res_load  = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            pulses_reg    <= window_reg;
            elapsed_reg   <= elapsed;
            grace_hit_reg <= ((cmd.now_ms - running_since_reg) >= 32'(fault_grace_ms));
        end
        if (state_reg == BK_MUL)
        begin
            product_reg <= NUM_W'(pulses_reg) * NUM_W'(RPM_HALF_SCALE);
        end
        if (res_load)
        begin
            res_reg.fan_on             <= on_reg;
            res_reg.fault              <= fault_reg;
            res_reg.rpm                <= rpm_reg;
            res_reg.window_pulses_seen <= 32'(last_window_reg);
            res_reg.total_pulses       <= 32'(total_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= BK_IDLE;
            on_reg            <= 1'b0;
            fault_reg         <= 1'b0;
            rpm_reg           <= '0;
            window_reg        <= '0;
            last_window_reg   <= '0;
            total_reg         <= '0;
            last_calc_reg     <= '0;
            running_since_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cmd_pop)
            begin
                if (cmd.kind == CMD_TACH)
                begin
                    window_reg <= window_reg + 1'b1;
                    total_reg  <= total_reg + 1'b1;
                end
                else if (switching)
                begin
                    on_reg            <= cmd.want;
                    rpm_reg           <= '0;
                    fault_reg         <= 1'b0;
                    window_reg        <= '0;
                    last_window_reg   <= '0;
                    last_calc_reg     <= cmd.now_ms;
                    running_since_reg <= cmd.want ? cmd.now_ms : '0;
                end
                else if (calc_due)
                begin
                    window_reg      <= '0;
                    last_window_reg <= window_reg;
                    last_calc_reg   <= cmd.now_ms;
                end
            end
            if (state_reg == BK_WAIT && div_done)
            begin
                rpm_reg <= div_quot;
                if (pulses_reg != '0 || div_quot != '0)
                begin
                    fault_reg <= 1'b0;
                end
                else if (grace_hit_reg)
                begin
                    fault_reg <= 1'b1;
                end
            end
        end
    end

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT) |-> (!res_valid_reg || pop))
        else $error("result written over an unread result");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == BK_WAIT))
        else $error("divider finished outside the wait state");

    a_calc_only_on: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MUL) |-> on_reg)
        else $error("speed calculation started with the fan off");

    a_fault_only_on: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> on_reg)
        else $error("fault raised while the fan is off");

endmodule

### bench/testbench.sv
// Self-checking bench for the fan tachometer monitor with directed and random requests.
`timescale 1ns / 100ps

module testbench;
    import ftrm_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    in_item_t    item    = '0;
    logic        pop     = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        full;
    logic        empty;
    res_item_t   result;
    logic [31:0] prdata;
    logic        pready;

    // Register copies and speed model state.
    logic        cfg_auto_mode  = RESET_AUTO_MODE;
    logic [15:0] cfg_publish_ms = RESET_PUBLISH_INT;
    logic [15:0] cfg_grace_ms   = RESET_FAULT_GRACE;
    logic        fan_running       = 1'b0;
    logic        stall_fault       = 1'b0;
    logic [15:0] speed_rpm         = '0;
    logic [31:0] window_edges      = '0;
    logic [31:0] prev_window_edges = '0;
    logic [31:0] edge_total        = '0;
    logic [31:0] calc_stamp        = '0;
    logic [31:0] start_stamp       = '0;

    res_item_t   pending_status[$];
    int          mismatches     = 0;
    int          rx_hold_cycles = 0;
    int          stall_cycles   = 0;
    logic        idle_on        = 1'b1;
    logic        want_on        = 1'b0;
    logic [31:0] clock_ms       = '0;

    fan_tach_rpm_monitor u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    function automatic res_item_t predict_status(input in_item_t req);
        logic        wanted;
        logic [31:0] span;
        logic [31:0] min_span;
        logic [31:0] edges;
        logic [63:0] quotient;
        res_item_t   res;
        if (req.req_type == CMD_TACH)
        begin
            window_edges = window_edges + 32'd1;
            edge_total   = edge_total + 32'd1;
        end
        else
        begin
            wanted   = cfg_auto_mode ? req.auto_demand : req.manual_on;
            min_span = (cfg_publish_ms == 16'd0) ? 32'd1 : {16'd0, cfg_publish_ms};
            if (wanted != fan_running)
            begin
                fan_running       = wanted;
                speed_rpm         = '0;
                stall_fault       = 1'b0;
                prev_window_edges = '0;
                window_edges      = '0;
                calc_stamp        = req.now_ms;
                start_stamp       = wanted ? req.now_ms : 32'd0;
            end
            span = req.now_ms - calc_stamp;
            if (fan_running && span >= min_span)
            begin
                edges             = window_edges;
                window_edges      = '0;
                prev_window_edges = edges;
                quotient          = (64'(edges) * 64'd60000) / (64'd2 * 64'(span));
                speed_rpm         = (quotient > 64'(RPM_MAX)) ? RPM_MAX : quotient[15:0];
                calc_stamp        = req.now_ms;
                span              = req.now_ms - start_stamp;
                if (edges != 32'd0)
                    stall_fault = 1'b0;
                else if (span >= {16'd0, cfg_grace_ms})
                    stall_fault = 1'b1;
            end
        end
        res.fan_on             = fan_running;
        res.fault              = stall_fault;
        res.rpm                = speed_rpm;
        res.window_pulses_seen = prev_window_edges;
        res.total_pulses       = edge_total;
        return res;
    endfunction

    function automatic in_item_t make_tick(input logic [31:0] now, input logic demand,
                                           input logic manual);
        in_item_t req;
        req.req_type    = CMD_TICK;
        req.now_ms      = now;
        req.auto_demand = demand;
        req.manual_on   = manual;
        return req;
    endfunction

    function automatic in_item_t tick_item(input logic level);
        logic other;
        other = 1'($urandom);
        return cfg_auto_mode ? make_tick(clock_ms, level, other)
                             : make_tick(clock_ms, other, level);
    endfunction

    // The time and switch fields of a tach edge carry noise that must be ignored.
    function automatic in_item_t tach_item();
        in_item_t req;
        req.req_type    = CMD_TACH;
        req.now_ms      = $urandom;
        req.auto_demand = 1'($urandom);
        req.manual_on   = 1'($urandom);
        return req;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    task automatic send_item(input in_item_t req);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full) @(posedge clk);
        pending_status.push_back(predict_status(req));
    endtask

    task automatic settle();
        push <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_AUTO_MODE:   cfg_auto_mode  = value[0];
            REG_PUBLISH_INT: cfg_publish_ms = value[15:0];
            REG_FAULT_GRACE: cfg_grace_ms   = value[15:0];
            default: ;
        endcase
    endtask

    // Unused upper bits of each register write carry noise.
    task automatic apply_settings(input logic auto_sel, input logic [15:0] interval,
                                  input logic [15:0] grace);
        settle();
        write_reg(REG_AUTO_MODE, {31'($urandom), auto_sel});
        write_reg(REG_PUBLISH_INT, {16'($urandom), interval});
        write_reg(REG_FAULT_GRACE, {16'($urandom), grace});
    endtask

    // Windows of tach edges closed by ticks, with occasional switching and time jumps.
    task automatic random_traffic(input int count);
        int          sent;
        int          burst;
        logic [31:0] span_lim;
        sent     = 0;
        span_lim = (cfg_publish_ms == 16'd0) ? 32'd2 : 32'd2 * cfg_publish_ms;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 6);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_item(tach_item());
                sent++;
            end
            if (sent < count)
            begin
                if ($urandom_range(0, 9) == 0)
                    want_on = ~want_on;
                if ($urandom_range(0, 31) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, span_lim);
                send_item(tick_item(want_on));
                sent++;
            end
        end
    endtask

    task automatic test_switching();
        send_item(tach_item());
        send_item(make_tick(32'd100, 1'b1, 1'b0));
        send_item(make_tick(32'd200, 1'b0, 1'b1));
        repeat (3) send_item(tach_item());
        send_item(make_tick(32'd1200, 1'b0, 1'b1));
        send_item(make_tick(32'd2200, 1'b0, 1'b1));
        send_item(make_tick(32'd5200, 1'b0, 1'b1));
        send_item(tach_item());
        send_item(make_tick(32'd6200, 1'b0, 1'b1));
        send_item(make_tick(32'd6300, 1'b1, 1'b0));
    endtask

    task automatic test_extremes();
        apply_settings(1'b1, 16'd1, 16'd0);
        send_item(make_tick(32'hFFFF_FFFE, 1'b1, 1'b0));
        repeat (6) send_item(tach_item());
        send_item(make_tick(32'hFFFF_FFFF, 1'b1, 1'b1));
        send_item(make_tick(32'h0000_0001, 1'b1, 1'b0));
        settle();
        write_reg(REG_PUBLISH_INT, 32'd0);
        send_item(make_tick(32'd1, 1'b1, 1'b0));
        send_item(make_tick(32'd2, 1'b1, 1'b0));
        send_item(make_tick(32'd3, 1'b0, 1'b1));
        clock_ms = 32'd3;
        want_on  = 1'b0;
    endtask

    task automatic test_random_settings();
        logic [15:0] interval;
        logic [15:0] grace;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase % 5)
                0:       interval = 16'd1;
                1:       interval = 16'd0;
                2:       interval = 16'hFFFF;
                3:       interval = 16'($urandom_range(2, 40));
                default: interval = 16'($urandom);
            endcase
            case (phase % 3)
                0:       grace = 16'd0;
                1:       grace = 16'hFFFF;
                default: grace = (interval < 16'd16000) ? 16'($urandom_range(0, 4 * interval))
                                                        : 16'($urandom);
            endcase
            apply_settings(1'(phase % 2), interval, grace);
            random_traffic(100);
        end
    endtask

    task automatic test_result_backpressure();
        rx_hold_cycles = 400;
        random_traffic(30);
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        apply_settings(1'b0, 16'd3, 16'd10);
        random_traffic(150);
    endtask

    initial
    begin : result_check
        res_item_t exp_res;
        int        rx_gap;
        rx_gap = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_status.size() == 0)
                begin
                    $error("result with no request pending: rpm %0d, total_pulses %0d",
                           result.rpm, result.total_pulses);
                    mismatches++;
                end
                else
                begin
                    exp_res = pending_status.pop_front();
                    check_field("fan_on", 32'(exp_res.fan_on), 32'(result.fan_on));
                    check_field("fault", 32'(exp_res.fault), 32'(result.fault));
                    check_field("rpm", 32'(exp_res.rpm), 32'(result.rpm));
                    check_field("window_pulses_seen", exp_res.window_pulses_seen,
                                result.window_pulses_seen);
                    check_field("total_pulses", exp_res.total_pulses, result.total_pulses);
                end
            end
            if (rx_hold_cycles > 0)
            begin
                pop <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_gap > 0)
            begin
                pop <= 1'b0;
                rx_gap--;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                pop <= 1'b0;
                rx_gap = $urandom_range(0, 14);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAIL fan_tach_rpm_monitor");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_switching();
        test_extremes();
        test_random_settings();
        test_result_backpressure();
        test_back_to_back();
        settle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("PASS fan_tach_rpm_monitor");
        else
            $display("FAIL fan_tach_rpm_monitor");
        $finish;
    end

endmodule
